// ===== rtl/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types and constants of the 3x3 matrix inverse core.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int MatDim  = 3;
  localparam int NumElem = MatDim * MatDim;
  localparam int ElemW   = 32;
  localparam int ProdW   = 2 * ElemW;      // one 2x2 minor product
  localparam int CofW    = ProdW + 1;      // cofactor, Q33.32
  localparam int DetW    = 99;             // determinant, Q51.48
  localparam int NumW    = 99;             // rounded numerator magnitude
  localparam int DenW    = DetW + 1;       // twice the determinant magnitude
  localparam int QBits   = 34;             // quotient bits kept below overflow
  localparam int RemW    = DenW + 1;       // partial remainder after shift
  localparam int HeadW   = NumW - QBits;   // numerator bits above the quotient

  localparam logic [ElemW-1:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [ElemW-1:0] SatNeg = 32'h8000_0000;
  localparam logic [QBits-1:0] LimPos = 34'h0_7FFF_FFFF;
  localparam logic [QBits-1:0] LimNeg = 34'h0_8000_0000;

  typedef logic signed [ElemW-1:0] elem_t;

  // one classified item handed from the front to the back
  typedef struct packed {
    logic                          singular;
    logic [NumElem-1:0]            neg;
    logic [NumElem-1:0][NumW-1:0]  num;
    logic [DenW-1:0]               den;
  } mi3_entry_t;

  // one stage of the restoring division pipeline
  typedef struct packed {
    logic                          singular;
    logic [NumElem-1:0]            neg;
    logic [NumElem-1:0]            ovf;
    logic [NumElem-1:0][RemW-1:0]  rem;
    logic [NumElem-1:0][QBits-1:0] quo;
    logic [NumElem-1:0][QBits-1:0] nlow;
    logic [DenW-1:0]               den;
  } mi3_stage_t;

  typedef struct packed {
    logic                          singular;
    logic [NumElem-1:0][ElemW-1:0] inv;
  } mi3_result_t;

endpackage

// ===== rtl/mi3_front.sv =====
// ----------------------------------------------------------------------------
// mi3_front
// Cofactors, determinant and singular check; hands divide jobs to the queue.
// ----------------------------------------------------------------------------
module mi3_front (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  start_i,
  input  logic [mi3_pkg::NumElem-1:0][mi3_pkg::ElemW-1:0]       a_i,
  input  logic                                                  full_i,
  output logic                                                  busy_o,
  output logic                                                  push_o,
  output mi3_pkg::mi3_entry_t                                   entry_o
);

  localparam int NE = mi3_pkg::NumElem;
  localparam int MD = mi3_pkg::MatDim;

  logic adv;
  logic [5:0] vld_q, vld_d;

  logic signed [mi3_pkg::ProdW-1:0] p_q [NE], m_q [NE];
  logic signed [mi3_pkg::CofW-1:0]  cof2_q [NE], cof3_q [NE], cof4_q [NE], cof5_q [NE];
  mi3_pkg::elem_t                   row1_q [MD], row2_q [MD];
  logic signed [mi3_pkg::CofW-1:0]  pl_q [MD], ph_q [MD];
  logic signed [mi3_pkg::DetW-1:0]  term_q [MD];
  logic signed [mi3_pkg::DetW-1:0]  det_q;
  mi3_pkg::mi3_entry_t              entry_q, entry_d;

  // hold the whole pipe only if the queue cannot take the last stage
  assign adv    = !vld_q[5] || !full_i;
  assign busy_o = !adv;
  assign push_o = vld_q[5] && adv;
  assign entry_o = entry_q;
  assign vld_d  = {vld_q[4:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // minor products: cofactor of (j,i) lands at adjugate place (i,j)
  for (genvar e = 0; e < NE; e++) begin : g_minor
    localparam int I  = e / MD;
    localparam int J  = e % MD;
    localparam int I1 = (I + 1) % MD;
    localparam int I2 = (I + 2) % MD;
    localparam int J1 = (J + 1) % MD;
    localparam int J2 = (J + 2) % MD;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        p_q[e]    <= $signed(a_i[J1*MD+I1]) * $signed(a_i[J2*MD+I2]);
        m_q[e]    <= $signed(a_i[J1*MD+I2]) * $signed(a_i[J2*MD+I1]);
        cof2_q[e] <= p_q[e] - m_q[e];
        cof3_q[e] <= cof2_q[e];
        cof4_q[e] <= cof3_q[e];
        cof5_q[e] <= cof4_q[e];
      end
    end
  end

  // determinant along the first row, 32 x 65 split into two partials
  for (genvar j = 0; j < MD; j++) begin : g_det
    always_ff @(posedge clk_i) begin
      if (adv) begin
        row1_q[j] <= $signed(a_i[j]);
        row2_q[j] <= row1_q[j];
        pl_q[j]   <= row2_q[j] * $signed({1'b0, cof2_q[j*MD][31:0]});
        ph_q[j]   <= row2_q[j] * $signed(cof2_q[j*MD][mi3_pkg::CofW-1:32]);
        term_q[j] <= (ph_q[j] <<< 32) + pl_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      det_q   <= term_q[0] + term_q[1] + term_q[2];
      entry_q <= entry_d;
    end
  end

  always_comb begin
    logic [mi3_pkg::DetW-1:0] absd;
    logic [mi3_pkg::CofW-1:0] absc;
    absd = det_q[mi3_pkg::DetW-1] ? (~det_q + 1'b1) : det_q;
    entry_d.singular = (det_q == '0);
    entry_d.den      = {absd, 1'b0};
    entry_d.neg      = '0;
    entry_d.num      = '0;
    for (int e = 0; e < NE; e++) begin
      absc = cof5_q[e][mi3_pkg::CofW-1] ? (~cof5_q[e] + 1'b1) : cof5_q[e];
      // 2*|C|*2^32 + |D| for round-half-away division
      entry_d.num[e] = {1'b0, absc, 33'b0} + absd;
      entry_d.neg[e] = cof5_q[e][mi3_pkg::CofW-1] ^ det_q[mi3_pkg::DetW-1];
    end
  end

endmodule

// ===== rtl/mi3_queue.sv =====
// ----------------------------------------------------------------------------
// mi3_queue
// Short FIFO between the front and the divide back end.
// ----------------------------------------------------------------------------
module mi3_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mi3_pkg::mi3_entry_t entry_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output mi3_pkg::mi3_entry_t head_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  mi3_pkg::mi3_entry_t mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== rtl/mi3_back.sv =====
// ----------------------------------------------------------------------------
// mi3_back
// Pipelined restoring division of nine numerators by one shared divisor,
// one quotient bit per stage, then sign and saturation.
// ----------------------------------------------------------------------------
module mi3_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  mi3_pkg::mi3_entry_t entry_i,
  output logic                pop_o,
  output logic                done_o,
  output mi3_pkg::mi3_result_t res_o
);

  localparam int NE = mi3_pkg::NumElem;
  localparam int QB = mi3_pkg::QBits;

  mi3_pkg::mi3_stage_t stage_q [QB+1];
  mi3_pkg::mi3_stage_t stage_d [QB+1];
  logic [QB:0]         vld_q;
  logic                done_q;
  mi3_pkg::mi3_result_t res_q, res_d;

  // the back end never stalls: take the queue head every cycle
  assign pop_o = valid_i;

  always_comb begin
    logic [mi3_pkg::HeadW-1:0] head;
    stage_d[0].singular = entry_i.singular;
    stage_d[0].neg      = entry_i.neg;
    stage_d[0].den      = entry_i.den;
    stage_d[0].ovf      = '0;
    stage_d[0].rem      = '0;
    stage_d[0].quo      = '0;
    stage_d[0].nlow     = '0;
    for (int e = 0; e < NE; e++) begin
      head = entry_i.num[e][mi3_pkg::NumW-1:QB];
      // a quotient of 2^34 or more saturates whatever its sign
      stage_d[0].ovf[e]  = {{(mi3_pkg::DenW-mi3_pkg::HeadW){1'b0}}, head} >= entry_i.den;
      stage_d[0].rem[e]  = {{(mi3_pkg::RemW-mi3_pkg::HeadW){1'b0}}, head};
      stage_d[0].nlow[e] = entry_i.num[e][QB-1:0];
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_div
    localparam int B = QB - s;
    always_comb begin
      logic [mi3_pkg::RemW-1:0] shifted;
      stage_d[s] = stage_q[s-1];
      for (int e = 0; e < NE; e++) begin
        shifted = {stage_q[s-1].rem[e][mi3_pkg::RemW-2:0], stage_q[s-1].nlow[e][B]};
        if (shifted >= {1'b0, stage_q[s-1].den}) begin
          stage_d[s].rem[e]    = shifted - {1'b0, stage_q[s-1].den};
          stage_d[s].quo[e][B] = 1'b1;
        end else begin
          stage_d[s].rem[e]    = shifted;
        end
      end
    end
  end

  for (genvar s = 0; s <= QB; s++) begin : g_reg
    always_ff @(posedge clk_i) begin
      stage_q[s] <= stage_d[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[QB-1:0], valid_i};
      done_q <= vld_q[QB];
    end
  end

  always_comb begin
    logic [QB-1:0] q;
    res_d.singular = stage_q[QB].singular;
    res_d.inv      = '0;
    for (int e = 0; e < NE; e++) begin
      q = stage_q[QB].quo[e];
      if (stage_q[QB].singular) begin
        res_d.inv[e] = '0;
      end else if (stage_q[QB].neg[e]) begin
        res_d.inv[e] = (stage_q[QB].ovf[e] || q > mi3_pkg::LimNeg) ?
                       mi3_pkg::SatNeg : (32'd0 - q[31:0]);
      end else begin
        res_d.inv[e] = (stage_q[QB].ovf[e] || q > mi3_pkg::LimPos) ?
                       mi3_pkg::SatPos : q[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/matrix_inverse_3x3_core.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_core
// Inverse of a 3x3 Q16.16 matrix by the adjugate, rounded and saturated.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a11_i..a33_i and raise start_i; the request is taken at a rising
//   edge with start_i high and busy_o low. A new request may follow every
//   cycle while busy_o is low: throughput is one matrix per clock.
//   The result appears on inv11_o..inv33_o and singular_o for exactly one
//   cycle, marked by done_o. The path to it runs through a six-stage front
//   (minor products, cofactors, split 32x65 determinant products and
//   sums), the hand-off queue, an entry stage that checks for quotient
//   overflow, a 34-stage restoring divider, one quotient bit per stage,
//   plus one output register.
//   A zero determinant raises singular_o with all elements zero. Quotients
//   outside Q16.16 saturate.
//   The receiver cannot stall; busy_o only rises if the hand-off queue
//   fills, which the always-draining back end prevents in practice.
//   Reset clears all valid flags; items in flight are dropped.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_core #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] a11_i,
  input  logic [31:0] a12_i,
  input  logic [31:0] a13_i,
  input  logic [31:0] a21_i,
  input  logic [31:0] a22_i,
  input  logic [31:0] a23_i,
  input  logic [31:0] a31_i,
  input  logic [31:0] a32_i,
  input  logic [31:0] a33_i,
  output logic        done_o,
  output logic [31:0] inv11_o,
  output logic [31:0] inv12_o,
  output logic [31:0] inv13_o,
  output logic [31:0] inv21_o,
  output logic [31:0] inv22_o,
  output logic [31:0] inv23_o,
  output logic [31:0] inv31_o,
  output logic [31:0] inv32_o,
  output logic [31:0] inv33_o,
  output logic        singular_o
);

  logic [mi3_pkg::NumElem-1:0][mi3_pkg::ElemW-1:0] a_in;
  logic                  push, full, empty;
  mi3_pkg::mi3_entry_t   push_entry, head;
  logic                  pop;
  mi3_pkg::mi3_result_t  res;

  assign a_in = {a33_i, a32_i, a31_i, a23_i, a22_i, a21_i, a13_i, a12_i, a11_i};

  mi3_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i && !busy_o),
    .a_i     (a_in),
    .full_i  (full),
    .busy_o  (busy_o),
    .push_o  (push),
    .entry_o (push_entry)
  );

  mi3_queue #(.DEPTH(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  mi3_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (!empty),
    .entry_i (head),
    .pop_o   (pop),
    .done_o  (done_o),
    .res_o   (res)
  );

  assign inv11_o    = res.inv[0];
  assign inv12_o    = res.inv[1];
  assign inv13_o    = res.inv[2];
  assign inv21_o    = res.inv[3];
  assign inv22_o    = res.inv[4];
  assign inv23_o    = res.inv[5];
  assign inv31_o    = res.inv[6];
  assign inv32_o    = res.inv[7];
  assign inv33_o    = res.inv[8];
  assign singular_o = res.singular;

`ifndef NO_ASSERTIONS
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && singular_o) |-> (inv11_o == '0 && inv22_o == '0 && inv33_o == '0 &&
                                inv12_o == '0 && inv21_o == '0))
    else $error("singular result with nonzero elements");
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("front stalled by a full queue");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for matrix_inverse_3x3_core: directed matrices, then
// random ones, checked against typed values or an adjugate inverse predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [31:0] One = 32'h0001_0000;

  typedef logic [31:0] mat_t [mi3_pkg::NumElem];

  typedef struct {
    logic [31:0] inv [mi3_pkg::NumElem];
    logic        singular;
  } inverse_t;

  typedef struct {
    mat_t        a;
    bit          typed;
    logic [31:0] inv [mi3_pkg::NumElem];
    logic        singular;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        done;
  logic        singular;
  logic [31:0] a_in [mi3_pkg::NumElem];
  logic [31:0] inv_out [mi3_pkg::NumElem];

  inverse_t expected_q [$];
  int       errors = 0;

  always #1 clk = ~clk;

  initial begin
    for (int k = 0; k < mi3_pkg::NumElem; k++) a_in[k] = '0;
  end

  matrix_inverse_3x3_core dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .a11_i(a_in[0]), .a12_i(a_in[1]), .a13_i(a_in[2]),
    .a21_i(a_in[3]), .a22_i(a_in[4]), .a23_i(a_in[5]),
    .a31_i(a_in[6]), .a32_i(a_in[7]), .a33_i(a_in[8]),
    .done_o(done),
    .inv11_o(inv_out[0]), .inv12_o(inv_out[1]), .inv13_o(inv_out[2]),
    .inv21_o(inv_out[3]), .inv22_o(inv_out[4]), .inv23_o(inv_out[5]),
    .inv31_o(inv_out[6]), .inv32_o(inv_out[7]), .inv33_o(inv_out[8]),
    .singular_o(singular)
  );

  // round(cof * 2^32 / det), ties away from zero, saturated to Q16.16
  function automatic logic [31:0] divide_q16(logic signed [127:0] cof,
                                             logic signed [127:0] det);
    logic         neg;
    logic [127:0] n, d, q;
    neg = cof[127] != det[127];
    n = (cof[127] ? -cof : cof) << 32;
    d = det[127] ? -det : det;
    q = (2 * n + d) / (2 * d);
    if (neg) return (q > 128'h8000_0000) ? mi3_pkg::SatNeg : 32'(-q);
    return (q > 128'h7FFF_FFFF) ? mi3_pkg::SatPos : q[31:0];
  endfunction

  function automatic inverse_t invert(mat_t a);
    inverse_t            r;
    logic signed [127:0] x [3][3];
    logic signed [127:0] adj [3][3];
    logic signed [127:0] det;
    mi3_pkg::elem_t      e;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        e = a[i*3+j];
        x[i][j] = e;
      end
    // adj[i][j] is the cofactor of element (j, i)
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        adj[i][j] = x[(j+1)%3][(i+1)%3] * x[(j+2)%3][(i+2)%3]
                  - x[(j+1)%3][(i+2)%3] * x[(j+2)%3][(i+1)%3];
    det = x[0][0] * adj[0][0] + x[0][1] * adj[1][0] + x[0][2] * adj[2][0];
    r.singular = (det == 0);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        r.inv[i*3+j] = r.singular ? 32'h0 : divide_q16(adj[i][j], det);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    inverse_t want;
    if (rst_n && done) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(singular), 32'h0);
      end else begin
        want = expected_q.pop_front();
        if (singular !== want.singular)
          report_mismatch("singular", 32'(singular), 32'(want.singular));
        for (int k = 0; k < mi3_pkg::NumElem; k++)
          if (inv_out[k] !== want.inv[k])
            report_mismatch($sformatf("inv%0d%0d", k / 3 + 1, k % 3 + 1),
                            inv_out[k], want.inv[k]);
      end
    end
  end

  // hold the request until taken, then queue what it should produce
  task automatic send(mat_t a, bit typed, inverse_t want, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    for (int k = 0; k < mi3_pkg::NumElem; k++) a_in[k] <= a[k];
    do @(posedge clk); while (busy);
    expected_q.push_back(typed ? want : invert(a));
  endtask

  function automatic logic [31:0] rand_elem(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      2: return 32'($signed($urandom_range(0, 64)) - 32);
      default: return ($urandom_range(0, 1) != 0) ? mi3_pkg::SatPos : mi3_pkg::SatNeg;
    endcase
  endfunction

  function automatic mat_t rand_matrix();
    mat_t a;
    int   mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < mi3_pkg::NumElem; k++)
      a[k] = (mode < 3) ? rand_elem(0) : (mode < 7) ? rand_elem(1) :
             (mode < 9) ? rand_elem(2) : rand_elem($urandom_range(0, 3));
    // make some dependent rows to reach the singular path
    if ($urandom_range(0, 7) == 0)
      for (int k = 0; k < 3; k++) a[6+k] = a[k];
    return a;
  endfunction

  localparam logic [31:0] SatPos = mi3_pkg::SatPos;
  localparam logic [31:0] SatNeg = mi3_pkg::SatNeg;

  row_t rows [] = '{
    '{'{One,0,0, 0,One,0, 0,0,One}, 1, '{One,0,0, 0,One,0, 0,0,One}, 1'b0},
    '{'{0,0,0, 0,0,0, 0,0,0}, 1, '{0,0,0, 0,0,0, 0,0,0}, 1'b1},
    '{'{SatPos,SatPos,SatPos, SatPos,SatPos,SatPos, SatPos,SatPos,SatPos},
      1, '{0,0,0, 0,0,0, 0,0,0}, 1'b1},
    '{'{SatNeg,SatNeg,SatNeg, SatNeg,SatNeg,SatNeg, SatNeg,SatNeg,SatNeg},
      1, '{0,0,0, 0,0,0, 0,0,0}, 1'b1},
    '{'{2*One,0,0, 0,2*One,0, 0,0,2*One}, 1,
      '{32'h8000,0,0, 0,32'h8000,0, 0,0,32'h8000}, 1'b0},
    // tiny nonzero determinant saturates instead of flagging
    '{'{1,0,0, 0,1,0, 0,0,1}, 1, '{SatPos,0,0, 0,SatPos,0, 0,0,SatPos}, 1'b0},
    '{'{32'hFFFF_FFFF,0,0, 0,32'hFFFF_FFFF,0, 0,0,32'hFFFF_FFFF}, 1,
      '{SatNeg,0,0, 0,SatNeg,0, 0,0,SatNeg}, 1'b0},
    '{'{SatNeg,0,0, 0,SatNeg,0, 0,0,SatNeg}, 1,
      '{32'hFFFF_FFFE,0,0, 0,32'hFFFF_FFFE,0, 0,0,32'hFFFF_FFFE}, 1'b0},
    '{'{SatPos,0,0, 0,SatPos,0, 0,0,SatPos}, 0, '{default: 0}, 1'b0},
    '{'{SatPos,0,0, 0,SatNeg,0, 0,0,1}, 0, '{default: 0}, 1'b0},
    '{'{0,One,0, 0,0,One, One,0,0}, 0, '{default: 0}, 1'b0},
    '{'{One,2*One,3*One, 0,One,4*One, 5*One,6*One,0}, 0, '{default: 0}, 1'b0},
    '{'{SatPos,SatNeg,1, 32'hFFFF_FFFF,SatPos,SatNeg, 0,1,SatPos}, 0,
      '{default: 0}, 1'b0},
    '{'{32'hAAAA_AAAA,32'h5555_5555,One, One,32'hAAAA_AAAA,32'h5555_5555,
        32'h5555_5555,One,32'hAAAA_AAAA}, 0, '{default: 0}, 1'b0}
  };

  initial begin
    inverse_t want;
    int       burst;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[r]) begin
      want.inv = rows[r].inv;
      want.singular = rows[r].singular;
      send(rows[r].a, rows[r].typed, want, (r % 3 == 0) ? 0 : $urandom_range(0, 9));
    end
    burst = 0;
    for (int n = 0; n < 500; n++) begin
      if (n == 250) begin
        start <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
      end
      if (burst == 0 && $urandom_range(0, 15) == 0) burst = $urandom_range(5, 30);
      send(rand_matrix(), 0, want, (burst > 0) ? 0 : $urandom_range(0, 9));
      if (burst > 0) burst--;
    end
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #200000;
    $display("simulation failed");
    $finish;
  end

endmodule
